// File: rtl/pktdfr_pkg.sv
// Package for the packet deframer with CRC-8 check.
// Holds the result record, result kind codes and the CRC-8 byte update.
// No dependencies.
package pktdfr_pkg;

  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'h00;
  localparam logic [6:0] CrcMask = 7'h7F;
  localparam logic [15:0] FailMax = 16'hFFFF;

  localparam logic ResData = 1'b0;
  localparam logic ResEnd  = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  packet_ident;
    logic [7:0]  payload_length;
    logic [7:0]  data_value;
    logic [7:0]  byte_position;
    logic        crc_ok;
    logic [15:0] crc_fail_total;
    logic        last;
  } res_t;

  // CRC-8, MSB first, one byte per call: eight shift steps on 8 bits
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// File: rtl/packet_deframer_crc_check.sv
// A payload or CRC byte gives its result in the output register, or in the skid entry.
// Throughput: one byte per cycle when not stalled, set by the phase update and CRC step.
// A one-entry skid stage behind the output register keeps input flowing while the
// output is stalled; input stalls only when both output and skid hold results.
// Reset (rst_ni low, async): waiting for header, header byte 0, all counts and CRC zero.
// Depends on pktdfr_pkg.
module packet_deframer_crc_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [7:0]  packet_ident_o,
  output logic [7:0]  payload_length_o,
  output logic [7:0]  data_value_o,
  output logic [7:0]  byte_position_o,
  output logic        crc_ok_o,
  output logic [15:0] crc_fail_total_o,
  output logic        last_o
);
  import pktdfr_pkg::*;

  localparam logic [2:0] PhWait = 3'd0;
  localparam logic [2:0] PhLen  = 3'd1;
  localparam logic [2:0] PhId   = 3'd2;
  localparam logic [2:0] PhData = 3'd3;
  localparam logic [2:0] PhCrc  = 3'd4;

  logic [7:0]  header_q;
  logic [2:0]  phase_q, phase_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  ident_q, ident_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] fail_q, fail_d;

  logic        out_valid_q, skid_valid_q;
  res_t        out_q, skid_q;
  res_t        res;
  logic        res_valid;
  logic        accept;
  logic        out_free;
  logic [8:0]  count_inc;
  logic        crc_match;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i & ~skid_valid_q;
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign count_inc  = {1'b0, count_q} + 9'd1;
  assign crc_match  = ({1'b0, crc_q[6:0] & CrcMask} == rx_byte_i);

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    ident_d   = ident_q;
    count_d   = count_q;
    crc_d     = crc_q;
    fail_d    = fail_q;
    res_valid = 1'b0;
    res       = '0;
    res.packet_ident   = ident_q;
    res.payload_length = len_q;
    res.crc_fail_total = fail_q;
    case (phase_q)
      PhWait: begin
        if (rx_byte_i == header_q) begin
          count_d = '0;
          crc_d   = CrcInit;
          phase_d = PhLen;
        end
      end
      PhLen: begin
        len_d   = rx_byte_i;
        phase_d = PhId;
      end
      PhId: begin
        ident_d = rx_byte_i;
        phase_d = (len_q == 8'd0) ? PhCrc : PhData;
      end
      PhData: begin
        res_valid         = 1'b1;
        res.result_kind   = ResData;
        res.data_value    = rx_byte_i;
        res.byte_position = count_q;
        crc_d             = crc8_update(crc_q, rx_byte_i);
        if (count_inc >= {1'b0, len_q}) begin
          phase_d = PhCrc;
        end
        count_d = count_inc[7:0];
      end
      PhCrc: begin
        if (!crc_match && fail_q != FailMax) begin
          fail_d = fail_q + 16'd1;
        end
        res_valid          = 1'b1;
        res.result_kind    = ResEnd;
        res.crc_ok         = crc_match;
        res.crc_fail_total = fail_d;
        res.last           = 1'b1;
        phase_d            = PhWait;
      end
      default: begin
        phase_d = PhWait;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= '0;
    end else if (cfg_we_i) begin
      header_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhWait;
      len_q   <= '0;
      ident_q <= '0;
      count_q <= '0;
      crc_q   <= CrcInit;
      fail_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      ident_q <= ident_d;
      count_q <= count_d;
      crc_q   <= crc_d;
      fail_q  <= fail_d;
    end
  end

  // output register with one skid entry; skid always drains first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q  <= accept & res_valid;
        end
      end else if (accept && res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept && res_valid) begin
        out_q <= res;
      end
    end else if (accept && res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = out_q.result_kind;
  assign packet_ident_o   = out_q.packet_ident;
  assign payload_length_o = out_q.payload_length;
  assign data_value_o     = out_q.data_value;
  assign byte_position_o  = out_q.byte_position;
  assign crc_ok_o         = out_q.crc_ok;
  assign crc_fail_total_o = out_q.crc_fail_total;
  assign last_o           = out_q.last;

endmodule

// File: rtl/pktdfr_checker.sv
// Port-level checks for the packet deframer, attached by bind.
// Depends on pktdfr_pkg and packet_deframer_crc_check.
module pktdfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        result_kind_o,
  input logic [7:0]  data_value_o,
  input logic [7:0]  byte_position_o,
  input logic        crc_ok_o,
  input logic [15:0] crc_fail_total_o,
  input logic        last_o
);
  import pktdfr_pkg::*;

  // held result's data, last and fail total must not change under stall
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_value_o)
      && $stable(last_o) && $stable(crc_fail_total_o))
    else $error("output changed while stalled");

  a_kind_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (result_kind_o == ResEnd)))
    else $error("last does not match result kind");

  a_report_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> data_value_o == 8'd0 && byte_position_o == 8'd0)
    else $error("end report carries data fields");

  a_data_no_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !crc_ok_o)
    else $error("crc_ok set on a data result");

endmodule

bind packet_deframer_crc_check pktdfr_checker u_pktdfr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .result_kind_o    (result_kind_o),
  .data_value_o     (data_value_o),
  .byte_position_o  (byte_position_o),
  .crc_ok_o         (crc_ok_o),
  .crc_fail_total_o (crc_fail_total_o),
  .last_o           (last_o)
);

// File: dv/packet_deframer_crc_check_tb.sv
// Testbench for packet_deframer_crc_check: directed and random byte streams with a
// self-checking predictor of the deframer and its CRC-8 check.
// Depends on pktdfr_pkg and the packet_deframer_crc_check RTL.
module packet_deframer_crc_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pktdfr_pkg::*;

  localparam int CycleLimit    = 200_000;
  localparam int HoldOffCycles = 300;
  localparam int RandItems     = 900;
  localparam int FailPackets   = 8;
  localparam int MaxPrints     = 40;
  localparam int SettleCycles  = 8;

  typedef enum logic [2:0] {PhHunt, PhLen, PhIdent, PhData, PhCrc} deframe_phase_e;
  typedef enum int {CrcGood, CrcFlip, CrcHighBit, CrcAny} crc_mode_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'h00;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        result_kind_o;
  logic [7:0]  packet_ident_o;
  logic [7:0]  payload_length_o;
  logic [7:0]  data_value_o;
  logic [7:0]  byte_position_o;
  logic        crc_ok_o;
  logic [15:0] crc_fail_total_o;
  logic        last_o;

  // predictor state
  deframe_phase_e ph      = PhHunt;
  logic [7:0]     hdr_sel = 8'h00;
  logic [7:0]     len_q   = 8'h00;
  logic [7:0]     ident_q = 8'h00;
  logic [7:0]     cnt_q   = 8'h00;
  logic [7:0]     crc_q   = 8'h00;
  logic [15:0]    fails_q = 16'h0000;
  res_t           pending_q[$];

  int err_count    = 0;
  int cycle_count  = 0;
  int in_idle_pct  = 30;
  int out_idle_pct = 30;
  int rx_hold      = 0;

  packet_deframer_crc_check u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .packet_ident_o   (packet_ident_o),
    .payload_length_o (payload_length_o),
    .data_value_o     (data_value_o),
    .byte_position_o  (byte_position_o),
    .crc_ok_o         (crc_ok_o),
    .crc_fail_total_o (crc_fail_total_o),
    .last_o           (last_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // bitwise form: feed each data bit, MSB first, into the top of the register
  function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[7] ^ b[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return crc;
  endfunction

  function automatic void model_byte(logic [7:0] b);
    res_t r;
    logic ok;
    r = '0;
    case (ph)
      PhHunt: begin
        if (b == hdr_sel) begin
          cnt_q = 8'h00;
          crc_q = 8'h00;
          ph    = PhLen;
        end
      end
      PhLen: begin
        len_q = b;
        ph    = PhIdent;
      end
      PhIdent: begin
        ident_q = b;
        ph      = (len_q == 8'h00) ? PhCrc : PhData;
      end
      PhData: begin
        r.result_kind    = ResData;
        r.packet_ident   = ident_q;
        r.payload_length = len_q;
        r.data_value     = b;
        r.byte_position  = cnt_q;
        r.crc_fail_total = fails_q;
        pending_q.push_back(r);
        crc_q = crc8_next(crc_q, b);
        if ({1'b0, cnt_q} + 9'd1 >= {1'b0, len_q}) ph = PhCrc;
        cnt_q = cnt_q + 8'd1;
      end
      PhCrc: begin
        // only 7 CRC bits are compared, so a byte with bit 7 set always fails
        ok = ({1'b0, crc_q[6:0]} == b);
        if (!ok && fails_q != 16'hFFFF) fails_q = fails_q + 16'd1;
        r.result_kind    = ResEnd;
        r.packet_ident   = ident_q;
        r.payload_length = len_q;
        r.crc_ok         = ok;
        r.crc_fail_total = fails_q;
        r.last           = 1'b1;
        pending_q.push_back(r);
        ph = PhHunt;
      end
      default: ph = PhHunt;
    endcase
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    err_count++;
    if (err_count <= MaxPrints)
      $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
  endtask

  task automatic check_result();
    res_t e;
    if (pending_q.size() == 0) begin
      report("result with no request pending", 32'(result_kind_o), 32'd0);
      return;
    end
    e = pending_q.pop_front();
    if (result_kind_o !== e.result_kind)
      report("result_kind", 32'(result_kind_o), 32'(e.result_kind));
    if (packet_ident_o !== e.packet_ident)
      report("packet_ident", 32'(packet_ident_o), 32'(e.packet_ident));
    if (payload_length_o !== e.payload_length)
      report("payload_length", 32'(payload_length_o), 32'(e.payload_length));
    if (data_value_o !== e.data_value)
      report("data_value", 32'(data_value_o), 32'(e.data_value));
    if (byte_position_o !== e.byte_position)
      report("byte_position", 32'(byte_position_o), 32'(e.byte_position));
    if (crc_ok_o !== e.crc_ok) report("crc_ok", 32'(crc_ok_o), 32'(e.crc_ok));
    if (crc_fail_total_o !== e.crc_fail_total)
      report("crc_fail_total", 32'(crc_fail_total_o), 32'(e.crc_fail_total));
    if (last_o !== e.last) report("last", 32'(last_o), 32'(e.last));
  endtask

  // receiver: check on accept, then pick next stall (long hold-off when requested)
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result();
    if (rx_hold > 0) begin
      out_stall_i <= 1'b1;
      rx_hold = rx_hold - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < out_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    model_byte(b);
  endtask

  // fill < 0 gives random payload bytes, otherwise every byte is fill
  task automatic send_packet(input logic [7:0] len, input logic [7:0] ident,
                             input crc_mode_e mode, input int fill);
    logic [7:0] crc;
    logic [7:0] b;
    logic [7:0] tail;
    int i;
    crc = 8'h00;
    send_byte(hdr_sel);
    send_byte(len);
    send_byte(ident);
    for (i = 0; i < len; i++) begin
      b   = (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
      crc = crc8_next(crc, b);
      send_byte(b);
    end
    case (mode)
      CrcGood:    tail = {1'b0, crc[6:0]};
      CrcFlip:    tail = {1'b0, crc[6:0]} ^ (8'h01 << $urandom_range(7));
      CrcHighBit: tail = 8'h80 | 8'($urandom_range(127));
      default:    tail = 8'($urandom_range(255));
    endcase
    send_byte(tail);
  endtask

  task automatic send_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(255));
      if (b == hdr_sel) b = ~b;
      send_byte(b);
    end
  endtask

  // header, length and ident, then the packet is cut short; later bytes are swallowed as payload
  task automatic send_broken();
    logic [7:0] len;
    len = 8'($urandom_range(2, 20));
    send_byte(hdr_sel);
    send_byte(len);
    send_byte(8'($urandom_range(255)));
    repeat ($urandom_range(0, len - 1)) send_byte(8'($urandom_range(255)));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_header(input logic [7:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hdr_sel = v;
  endtask

  task automatic test_reset_header();
    // header resets to zero: a stray byte is dropped, then an empty packet passes
    send_byte(8'h55);
    send_packet(8'h00, 8'hFF, CrcGood, -1);
  endtask

  task automatic test_directed_cases();
    write_header(8'hFF);
    send_packet(8'h01, 8'h00, CrcGood, 0);
    send_packet(8'h01, 8'h80, CrcHighBit, 'hFF);
    send_packet(8'h02, 8'h7F, CrcFlip, -1);
  endtask

  task automatic test_long_packet();
    send_packet(8'hFF, 8'($urandom_range(255)), CrcGood, -1);
    drain();
  endtask

  task automatic test_backpressure();
    // receiver holds off while the sender keeps offering, so the input stalls
    in_idle_pct = 0;
    rx_hold = HoldOffCycles;
    send_packet(8'd40, 8'h3C, CrcGood, -1);
    drain();
    in_idle_pct = 30;
  endtask

  task automatic rand_traffic(input int target);
    int count;
    int sel;
    int roll;
    logic [7:0] len;
    crc_mode_e mode;
    count = 0;
    while (count < target) begin
      sel = $urandom_range(99);
      if (sel < 80) begin
        len  = ($urandom_range(9) == 0) ? 8'($urandom_range(32)) : 8'($urandom_range(6));
        roll = $urandom_range(99);
        mode = (roll < 70) ? CrcGood : (roll < 85) ? CrcFlip :
               (roll < 93) ? CrcHighBit : CrcAny;
        send_packet(len, 8'($urandom_range(255)), mode, -1);
        count += len + 4;
      end else if (sel < 92) begin
        send_noise($urandom_range(1, 3));
      end else begin
        send_broken();
        count += 4;
      end
    end
  endtask

  task automatic test_random_traffic();
    write_header(8'hA5);
    rand_traffic(RandItems / 4);
    // a long stretch with no idling on either side
    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_header(8'($urandom_range(1, 254)));
    rand_traffic(RandItems / 4);
    in_idle_pct  = 30;
    out_idle_pct = 30;
    write_header(8'h00);
    rand_traffic(RandItems / 4);
    write_header(8'hFF);
    rand_traffic(RandItems / 4);
    drain();
  endtask

  task automatic test_fail_count();
    // a run of failing empty packets steps the failure count
    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (FailPackets) send_packet(8'h00, 8'($urandom_range(255)), CrcHighBit, -1);
    in_idle_pct  = 30;
    out_idle_pct = 30;
    send_packet(8'h03, 8'h11, CrcGood, -1);
    send_packet(8'h02, 8'h22, CrcFlip, -1);
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_header();
    test_directed_cases();
    test_long_packet();
    test_backpressure();
    test_random_traffic();
    test_fail_count();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/pktdfr_pkg.sv
rtl/packet_deframer_crc_check.sv
rtl/pktdfr_checker.sv
dv/packet_deframer_crc_check_tb.sv
